FILE: sv/adaptive_routing_mode_selector_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the adaptive routing mode selector
// Shared concurrent assertion forms used by the port checker.
// ---------------------------------------------------------------------------
`ifndef ADAPTIVE_ROUTING_MODE_SELECTOR_DEFINES_SVH
`define ADAPTIVE_ROUTING_MODE_SELECTOR_DEFINES_SVH

// Property checked on every clock edge outside reset.
`define ARMS_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("arms assertion failed");

// Property checked on every clock edge, reset included.
`define ARMS_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("arms assertion failed");

`endif

FILE: sv/arms_pkg.sv
// ---------------------------------------------------------------------------
// arms_pkg
// Types, constants and codes shared by the routing mode selector modules.
// ---------------------------------------------------------------------------
package arms_pkg;

   localparam int COUNTER_BITS_DEFAULT = 48;
   localparam int FRAC_BITS_DEFAULT    = 16;

   localparam int LEN_BITS  = 32;
   localparam int MODE_BITS = 16;
   localparam int EP_BITS   = 16;
   localparam int FL_BITS   = 8;
   localparam int ACC_BITS  = 64;
   localparam int Q_BITS    = 48;
   localparam int SGN_BITS  = Q_BITS + 4;
   localparam int MAG_BITS  = Q_BITS + 3;
   localparam int F64_BITS  = LEN_BITS + 3;
   localparam int PROD_BITS = F64_BITS + MAG_BITS;
   localparam int MUL_STEPS = MAG_BITS;
   localparam int MCNT_BITS = $clog2(MUL_STEPS + 1);
   localparam int RSP_DATA_BITS = 24;
   localparam int CSR_IDX_BITS  = 2;
   localparam int CSR_DATA_BITS = 32;

   localparam logic [LEN_BITS-1:0]  CUTOFF_RESET    = 32'd4096;
   localparam logic [MODE_BITS-1:0] LL_CODE_RESET   = 16'd3;
   localparam logic [MODE_BITS-1:0] LS_CODE_RESET   = 16'd0;
   localparam logic [FL_BITS-1:0]   FRESH_LIM_RESET = 8'd5;
   localparam logic [MODE_BITS-1:0] MODE_NONE       = 16'hFFFF;

   // Cycle-scale factors of the cost model, per decision case.
   localparam logic [9:0] C_FRESH = 10'd800;
   localparam logic [9:0] C_LL    = 10'd200;
   localparam logic [9:0] C_LS    = 10'd100;

   localparam logic [CSR_IDX_BITS-1:0] CSR_CUTOFF    = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_LL_CODE   = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_LS_CODE   = 2'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_FRESH_LIM = 2'd3;

   localparam logic OP_BULK  = 1'b0;
   localparam logic OP_SHORT = 1'b1;

   localparam logic DIV_SEL_LAT   = 1'b0;
   localparam logic DIV_SEL_STALL = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PREP,
      ST_MUL,
      ST_PICK,
      ST_DLOAD_LAT,
      ST_DRUN_LAT,
      ST_DLOAD_STL,
      ST_DRUN_STL
   } arms_state_type;

   typedef struct packed {
      logic accept;
      logic prep;
      logic mul_step;
      logic pick;
      logic div_load;
      logic div_step;
      logic div_sel;
      logic emit;
   } arms_cmd_type;

   typedef struct packed {
      logic need_mul;
      logic need_div;
      logic div_pend;
      logic mul_last;
      logic div_last;
   } arms_status_type;

endpackage

FILE: sv/adaptive_routing_mode_selector.sv
// ---------------------------------------------------------------------------
// adaptive_routing_mode_selector
// Chooses a low-latency or low-stall routing mode for each network post.
// ---------------------------------------------------------------------------
// One post is handled at a time. A short message or a bulk post that only
// accumulates goes from the prep state straight to the final state, which
// emits its result beat. A post that runs the cost model adds the
// bit-serial product compare (one multiplier bit a cycle over 51 bits, then
// the pick), and a post that takes a new measurement adds the two radix-2
// divisions of COUNTER_BITS + FRAC_BITS quotient bits each. Every post may
// also wait in the final state for the output register to free up.
// The next post is accepted while the previous result waits on rsp_tready.
// Configuration writes are taken in every cycle.
module adaptive_routing_mode_selector #(
   parameter int COUNTER_BITS = arms_pkg::COUNTER_BITS_DEFAULT,
   parameter int FRAC_BITS    = arms_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    csr_valid,
   output logic                                    csr_ready,
   input  logic [arms_pkg::CSR_IDX_BITS-1:0]       csr_index,
   input  logic [arms_pkg::CSR_DATA_BITS-1:0]      csr_data,
   input  logic                                    req_tvalid,
   output logic                                    req_tready,
   // length_bytes, is_get, endpoint_id, req_flits, req_stalled,
   // rsp_latency_sum, rsp_tracked, rsp_stalled, zero fill
   input  logic [((49+5*COUNTER_BITS+7)/8)*8-1:0]  req_tdata,
   // operation
   input  logic                                    req_tuser,
   output logic                                    rsp_tvalid,
   input  logic                                    rsp_tready,
   // routing_mode, mode_changed, zero fill
   output logic [arms_pkg::RSP_DATA_BITS-1:0]      rsp_tdata
);
   import arms_pkg::*;

   arms_cmd_type    cmd;
   arms_status_type status;

   assign csr_ready = 1'b1;

   arms_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   arms_dp #(
      .COUNTER_BITS (COUNTER_BITS),
      .FRAC_BITS    (FRAC_BITS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tdata (rsp_tdata),
      .cmd       (cmd),
      .status    (status)
   );

endmodule

FILE: sv/arms_ctrl.sv
// ---------------------------------------------------------------------------
// arms_ctrl
// Sequencer of the routing mode selector: accepts a post, steps the
// multiplier and divider, and owns the result beat's valid flag.
// ---------------------------------------------------------------------------
module arms_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   input  arms_pkg::arms_status_type status,
   output arms_pkg::arms_cmd_type    cmd
);
   import arms_pkg::*;

   arms_state_type state_ff, state_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           slot_free;

   // The result is emitted only from the final state, once the mode registers
   // hold this post's outcome and the output register can take it.
   logic emit_now;

   assign slot_free = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) state_in = ST_PREP;
         end
         ST_PREP: begin
            if (status.need_mul) state_in = ST_MUL;
            else if (status.need_div) state_in = ST_DLOAD_LAT;
            else state_in = ST_DRUN_STL;
         end
         ST_MUL: begin
            if (status.mul_last) state_in = ST_PICK;
         end
         ST_PICK: begin
            if (status.div_pend) state_in = ST_DLOAD_LAT;
            else state_in = ST_DRUN_STL;
         end
         ST_DLOAD_LAT: state_in = ST_DRUN_LAT;
         ST_DRUN_LAT: begin
            if (status.div_last) state_in = ST_DLOAD_STL;
         end
         ST_DLOAD_STL: state_in = ST_DRUN_STL;
         ST_DRUN_STL: begin
            // Also serves as the wait for a free output slot once the
            // divider has finished or when no division was needed.
            if (emit_now) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Emission happens at the end of the stall division, or while waiting for
   // the output slot.
   logic div_done_ff, div_done_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         div_done_ff <= 1'b0;
      end else begin
         div_done_ff <= div_done_in;
      end
   end

   always_comb begin
      div_done_in = div_done_ff;
      case (state_ff)
         ST_PREP:      div_done_in = !status.need_mul && !status.need_div;
         ST_PICK:      div_done_in = !status.div_pend;
         ST_DLOAD_STL: div_done_in = 1'b0;
         ST_DRUN_STL:  begin
            if (status.div_last) div_done_in = 1'b1;
            if (emit_now) div_done_in = 1'b0;
         end
         default: div_done_in = div_done_ff;
      endcase
   end

   always_comb begin
      emit_now = 1'b0;
      case (state_ff)
         ST_DRUN_STL: emit_now = (div_done_ff || status.div_last) && slot_free;
         default:     emit_now = 1'b0;
      endcase
   end

   always_comb begin
      cmd          = '0;
      req_tready   = (state_ff == ST_IDLE);
      cmd.accept   = (state_ff == ST_IDLE) && req_tvalid;
      cmd.emit     = emit_now;
      case (state_ff)
         ST_PREP:      cmd.prep = 1'b1;
         ST_MUL:       cmd.mul_step = 1'b1;
         ST_PICK:      cmd.pick = 1'b1;
         ST_DLOAD_LAT: begin
            cmd.div_load = 1'b1;
            cmd.div_sel  = DIV_SEL_LAT;
         end
         ST_DRUN_LAT:  begin
            cmd.div_step = 1'b1;
            cmd.div_sel  = DIV_SEL_LAT;
         end
         ST_DLOAD_STL: begin
            cmd.div_load = 1'b1;
            cmd.div_sel  = DIV_SEL_STALL;
         end
         ST_DRUN_STL:  begin
            cmd.div_step = !div_done_ff;
            cmd.div_sel  = DIV_SEL_STALL;
         end
         default:      cmd.prep = 1'b0;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_tready) rsp_valid_in = 1'b0;
      if (emit_now) rsp_valid_in = 1'b1;
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule

FILE: sv/arms_dp.sv
// ---------------------------------------------------------------------------
// arms_dp
// Datapath of the routing mode selector: configuration, decision state,
// shift-add product compare and radix-2 fixed-point divider.
// ---------------------------------------------------------------------------
module arms_dp #(
   parameter int COUNTER_BITS = arms_pkg::COUNTER_BITS_DEFAULT,
   parameter int FRAC_BITS    = arms_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    csr_valid,
   input  logic [arms_pkg::CSR_IDX_BITS-1:0]       csr_index,
   input  logic [arms_pkg::CSR_DATA_BITS-1:0]      csr_data,
   input  logic [((49+5*COUNTER_BITS+7)/8)*8-1:0]  req_tdata,
   input  logic                                    req_tuser,
   output logic [arms_pkg::RSP_DATA_BITS-1:0]      rsp_tdata,
   input  arms_pkg::arms_cmd_type                  cmd,
   output arms_pkg::arms_status_type               status
);
   import arms_pkg::*;

   localparam int CB        = COUNTER_BITS;
   localparam int DIV_STEPS = COUNTER_BITS + FRAC_BITS;
   localparam int DCNT_BITS = $clog2(DIV_STEPS + 1);
   localparam int OFS_GET   = LEN_BITS;
   localparam int OFS_EP    = LEN_BITS + 1;
   localparam int OFS_CNT   = LEN_BITS + 1 + EP_BITS;

   // Configuration
   logic [LEN_BITS-1:0]  cutoff_ff;
   logic [MODE_BITS-1:0] ll_code_ff, ls_code_ff;
   logic [FL_BITS-1:0]   fresh_lim_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cutoff_ff    <= CUTOFF_RESET;
         ll_code_ff   <= LL_CODE_RESET;
         ls_code_ff   <= LS_CODE_RESET;
         fresh_lim_ff <= FRESH_LIM_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_CUTOFF:    cutoff_ff    <= csr_data;
            CSR_LL_CODE:   ll_code_ff   <= csr_data[MODE_BITS-1:0];
            CSR_LS_CODE:   ls_code_ff   <= csr_data[MODE_BITS-1:0];
            CSR_FRESH_LIM: fresh_lim_ff <= csr_data[FL_BITS-1:0];
            default:       cutoff_ff    <= cutoff_ff;
         endcase
      end
   end

   // Captured request
   logic                 op_ff, get_ff;
   logic [LEN_BITS-1:0]  len_ff;
   logic [EP_BITS-1:0]   ep_ff;
   logic [CB-1:0]        cnt_ff [5];

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         op_ff  <= req_tuser;
         len_ff <= req_tdata[LEN_BITS-1:0];
         get_ff <= req_tdata[OFS_GET];
         ep_ff  <= req_tdata[OFS_EP +: EP_BITS];
         for (int i = 0; i < 5; i++) begin
            cnt_ff[i] <= req_tdata[OFS_CNT + i*CB +: CB];
         end
      end
   end

   // Decision and measurement state
   logic [MODE_BITS-1:0] cur_mode_ff, dec_mode_ff;
   logic                 changed_ff;
   logic [ACC_BITS-1:0]  dacc_ff, macc_ff;
   logic [CB-1:0]        snap_ff [5];
   logic                 first_ff, mvalid_ff;
   logic [Q_BITS-1:0]    sr_ff, lat_ff;
   logic [FL_BITS-1:0]   fcnt_ff [2];
   logic [Q_BITS-1:0]    s_stall_ff [2];
   logic [Q_BITS-1:0]    s_lat_ff [2];
   logic [EP_BITS-1:0]   s_ep_ff [2];
   logic [LEN_BITS-1:0]  s_len_ff [2];
   logic                 in_ll_ff, div_pend_ff;

   // Multiplier and divider registers
   logic [PROD_BITS-1:0] ma_ff, mc_ff, p1_ff, p2_ff;
   logic [MAG_BITS-1:0]  mb_ff, mn_ff;
   logic [MCNT_BITS-1:0] mcnt_ff;
   logic [CB-1:0]        lsum_ff, trk_ff, snum_ff, flits_ff;
   logic                 szero_ff;
   logic [CB-1:0]        dnum_ff, dden_ff, drem_ff;
   logic [Q_BITS:0]      dq_ff;
   logic [DCNT_BITS-1:0] dcnt_ff;

   // Preparation logic
   logic [ACC_BITS-1:0]  dacc_sum, macc_sum;
   logic                 below_cut, eval, meas, good;
   logic                 in_ll, mine, other, fresh;
   logic [FL_BITS-1:0]   fc_other, fc_dec;
   logic signed [SGN_BITS-1:0] sr_s, lat_s, so_s, lo_s, n_raw, d_raw, n_adj, d_adj;
   logic                 d_zero, n_neg;
   logic [LEN_BITS:0]    len_up;
   logic [26:0]          pkts;
   logic [27:0]          alpha_sum;
   logic [9:0]           factor;
   logic [27:0]          cfac;
   logic [F64_BITS-1:0]  f64;
   logic [MODE_BITS-1:0] pre_pick, bulk_next;
   logic [CB-1:0]        dl [5];

   always_comb begin
      dacc_sum  = dacc_ff + {{(ACC_BITS-LEN_BITS){1'b0}}, len_ff};
      macc_sum  = macc_ff + {{(ACC_BITS-LEN_BITS){1'b0}}, len_ff};
      below_cut = dacc_sum <= {{(ACC_BITS-LEN_BITS){1'b0}}, cutoff_ff};
      eval      = !below_cut && mvalid_ff;
      meas      = macc_sum > {{(ACC_BITS-LEN_BITS){1'b0}}, cutoff_ff};
      good      = (cnt_ff[3] > snap_ff[3]) && (cnt_ff[0] > snap_ff[0]) && !first_ff;
      for (int i = 0; i < 5; i++) dl[i] = cnt_ff[i] - snap_ff[i];

      in_ll    = (dec_mode_ff == ll_code_ff);
      mine     = in_ll;
      other    = !in_ll;
      fc_other = fcnt_ff[other];
      fc_dec   = (fc_other != '0) ? fc_other - 8'd1 : '0;
      fresh    = (fc_dec != '0) && (s_ep_ff[other] == ep_ff) && (s_len_ff[other] == len_ff);

      sr_s  = signed'({4'b0, sr_ff});
      lat_s = signed'({4'b0, lat_ff});
      so_s  = signed'({4'b0, s_stall_ff[other]});
      lo_s  = signed'({4'b0, s_lat_ff[other]});
      if (in_ll) begin
         if (fresh) begin
            n_raw = lo_s - lat_s;  d_raw = sr_s - so_s;  factor = C_FRESH;
         end else begin
            n_raw = lat_s;         d_raw = sr_s;         factor = C_LL;
         end
      end else begin
         if (fresh) begin
            n_raw = lat_s - lo_s;  d_raw = so_s - sr_s;  factor = C_FRESH;
         end else begin
            n_raw = lat_s;         d_raw = sr_s + (sr_s <<< 1);  factor = C_LS;
         end
      end
      if (d_raw < 0) begin
         d_adj = -d_raw;  n_adj = -n_raw;
      end else begin
         d_adj = d_raw;   n_adj = n_raw;
      end
      d_zero = (d_raw == '0);
      n_neg  = (n_adj < 0);

      len_up    = {1'b0, len_ff} + 33'd63;
      pkts      = len_up[LEN_BITS:6];
      alpha_sum = {1'b0, pkts} + 28'd1534;
      cfac      = alpha_sum[27:10] * factor;
      f64       = get_ff ? {3'b0, len_ff} : ({3'b0, len_ff} << 2) + {3'b0, len_ff};

      pre_pick  = d_zero ? ll_code_ff : ls_code_ff;
      bulk_next = below_cut ? ll_code_ff : cur_mode_ff;
   end

   // Product compare
   logic p_gt, p_lt;
   logic [MODE_BITS-1:0] mul_pick;
   assign p_gt     = p1_ff > p2_ff;
   assign p_lt     = p1_ff < p2_ff;
   assign mul_pick = in_ll_ff ? (p_gt ? ls_code_ff : ll_code_ff)
                              : (p_lt ? ll_code_ff : ls_code_ff);

   // Divider step
   logic [CB:0]      rem_sh, rem_nx;
   logic             q_bit;
   logic [Q_BITS+1:0] q_sh;
   logic [Q_BITS:0]   q_nx;
   logic [Q_BITS-1:0] q_fin;

   always_comb begin
      rem_sh = {drem_ff, dnum_ff[CB-1]};
      q_bit  = rem_sh >= {1'b0, dden_ff};
      rem_nx = q_bit ? rem_sh - {1'b0, dden_ff} : rem_sh;
      q_sh   = {dq_ff, q_bit};
      // Saturation keeps the quotient pinned one above the Q maximum.
      q_nx   = (q_sh[Q_BITS+1:Q_BITS] != 2'b00) ? {1'b1, {Q_BITS{1'b0}}} : q_sh[Q_BITS:0];
      q_fin  = q_nx[Q_BITS] ? {Q_BITS{1'b1}} : q_nx[Q_BITS-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_mode_ff <= MODE_NONE;
         dec_mode_ff <= MODE_NONE;
         changed_ff  <= 1'b0;
         dacc_ff     <= '0;
         macc_ff     <= '0;
         first_ff    <= 1'b1;
         mvalid_ff   <= 1'b0;
         sr_ff       <= '0;
         lat_ff      <= '0;
         div_pend_ff <= 1'b0;
         for (int i = 0; i < 5; i++) snap_ff[i] <= '0;
         for (int i = 0; i < 2; i++) begin
            fcnt_ff[i]    <= '0;
            s_stall_ff[i] <= '0;
            s_lat_ff[i]   <= '0;
            s_ep_ff[i]    <= '0;
            s_len_ff[i]   <= '0;
         end
      end else begin
         if (cmd.prep) begin
            div_pend_ff <= 1'b0;
            if (op_ff == OP_SHORT) begin
               cur_mode_ff <= ll_code_ff;
               changed_ff  <= 1'b1;
            end else begin
               if (eval) begin
                  dacc_ff          <= '0;
                  fcnt_ff[mine]    <= fresh_lim_ff;
                  fcnt_ff[other]   <= fc_dec;
                  s_stall_ff[mine] <= sr_ff;
                  s_lat_ff[mine]   <= lat_ff;
                  s_ep_ff[mine]    <= ep_ff;
                  s_len_ff[mine]   <= len_ff;
                  if (d_zero || n_neg) begin
                     dec_mode_ff <= pre_pick;
                     cur_mode_ff <= pre_pick;
                     changed_ff  <= (pre_pick != cur_mode_ff);
                  end
               end else begin
                  dacc_ff     <= dacc_sum;
                  cur_mode_ff <= bulk_next;
                  changed_ff  <= (bulk_next != cur_mode_ff);
               end
               if (meas) begin
                  macc_ff <= '0;
                  for (int i = 0; i < 5; i++) snap_ff[i] <= cnt_ff[i];
                  if (good) div_pend_ff <= 1'b1;
                  else first_ff <= 1'b0;
               end else begin
                  macc_ff <= macc_sum;
               end
            end
         end
         if (cmd.pick) begin
            dec_mode_ff <= mul_pick;
            cur_mode_ff <= mul_pick;
            changed_ff  <= (mul_pick != cur_mode_ff);
         end
         if (cmd.div_step && dcnt_ff == DCNT_BITS'(1)) begin
            if (cmd.div_sel == DIV_SEL_LAT) begin
               lat_ff <= q_fin;
            end else begin
               sr_ff     <= szero_ff ? '0 : q_fin;
               mvalid_ff <= 1'b1;
            end
         end
      end
   end

   // Operand registers of the multiplier and divider
   always_ff @(posedge clock) begin
      if (cmd.prep) begin
         in_ll_ff <= in_ll;
         ma_ff    <= {{(PROD_BITS-F64_BITS){1'b0}}, f64};
         mc_ff    <= {{(PROD_BITS-34){1'b0}}, cfac, 6'b0};
         mb_ff    <= d_adj[MAG_BITS-1:0];
         mn_ff    <= n_adj[MAG_BITS-1:0];
         p1_ff    <= '0;
         p2_ff    <= '0;
         mcnt_ff  <= MCNT_BITS'(MUL_STEPS);
         lsum_ff  <= dl[2];
         trk_ff   <= dl[3];
         flits_ff <= dl[0];
         szero_ff <= dl[4] >= dl[1];
         snum_ff  <= dl[1] - dl[4];
      end
      if (cmd.mul_step) begin
         p1_ff   <= p1_ff + (mb_ff[0] ? ma_ff : '0);
         p2_ff   <= p2_ff + (mn_ff[0] ? mc_ff : '0);
         ma_ff   <= ma_ff << 1;
         mc_ff   <= mc_ff << 1;
         mb_ff   <= mb_ff >> 1;
         mn_ff   <= mn_ff >> 1;
         mcnt_ff <= mcnt_ff - MCNT_BITS'(1);
      end
      if (cmd.div_load) begin
         dnum_ff <= (cmd.div_sel == DIV_SEL_LAT) ? lsum_ff : snum_ff;
         dden_ff <= (cmd.div_sel == DIV_SEL_LAT) ? trk_ff : flits_ff;
         drem_ff <= '0;
         dq_ff   <= '0;
         dcnt_ff <= DCNT_BITS'(DIV_STEPS);
      end
      if (cmd.div_step) begin
         dnum_ff <= dnum_ff << 1;
         drem_ff <= rem_nx[CB-1:0];
         dq_ff   <= q_nx;
         dcnt_ff <= dcnt_ff - DCNT_BITS'(1);
      end
   end

   // Result beat payload
   logic [MODE_BITS-1:0] rsp_mode_ff;
   logic                 rsp_chg_ff;

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_mode_ff <= cur_mode_ff;
         rsp_chg_ff  <= changed_ff;
      end
   end

   assign rsp_tdata = {{(RSP_DATA_BITS-MODE_BITS-1){1'b0}}, rsp_chg_ff, rsp_mode_ff};

   assign status.need_mul = (op_ff == OP_BULK) && eval && !d_zero && !n_neg;
   assign status.need_div = (op_ff == OP_BULK) && meas && good;
   assign status.div_pend = div_pend_ff;
   assign status.mul_last = (mcnt_ff == MCNT_BITS'(1));
   assign status.div_last = (dcnt_ff == DCNT_BITS'(1));

endmodule

FILE: sv/arms_checker.sv
// ---------------------------------------------------------------------------
// arms_checker
// Port-level checks of the routing mode selector, bound to the top level.
// ---------------------------------------------------------------------------
`include "adaptive_routing_mode_selector_defines.svh"

module arms_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_tvalid,
   input logic                                req_tready,
   input logic                                rsp_tvalid,
   input logic                                rsp_tready,
   input logic [arms_pkg::RSP_DATA_BITS-1:0]  rsp_tdata
);
   import arms_pkg::*;

   // A held result beat keeps its valid and its payload.
   `ARMS_ASSERT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid)
   `ARMS_ASSERT(a_rsp_stable, clock, reset, rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata))
   // Posts are worked one at a time, so ready drops right after an accept.
   `ARMS_ASSERT(a_one_at_a_time, clock, reset, req_tvalid && req_tready |=> !req_tready)
   // Reset leaves no result beat behind.
   `ARMS_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_tvalid)

endmodule

bind adaptive_routing_mode_selector arms_checker u_arms_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

FILE: tb/adaptive_routing_mode_selector_test.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Routing mode selector testbench
// Sends bulk posts and short messages with running counter values, predicts
// the routing mode of every post and checks each response beat against it.
// The sender pauses between bursts and the receiver stalls on a pattern.
// ---------------------------------------------------------------------------
module adaptive_routing_mode_selector_test;
   import arms_pkg::*;

   localparam int CNT_W   = COUNTER_BITS_DEFAULT;
   localparam int FRAC_W  = FRAC_BITS_DEFAULT;
   localparam int REQ_W   = ((49 + 5 * CNT_W + 7) / 8) * 8;
   localparam int DRAIN   = 400;
   localparam int IDLE_MAX = 20000;

   typedef struct packed {
      logic                    op;
      logic [LEN_BITS-1:0]     len;
      logic                    is_get;
      logic [EP_BITS-1:0]      ep;
      logic [4:0][CNT_W-1:0]   cnt;
   } post_type;

   typedef struct packed {
      logic [MODE_BITS-1:0] mode;
      logic                 changed;
   } mode_result_type;

   class mode_scoreboard;
      logic [LEN_BITS-1:0]  cutoff;
      logic [MODE_BITS-1:0] ll_code, ls_code;
      logic [FL_BITS-1:0]   fresh_lim;
      logic [MODE_BITS-1:0] cur_mode, decided;
      logic [63:0]          decide_sum, measure_sum;
      logic [4:0][CNT_W-1:0] snap;
      bit                   first_meas, have_metrics;
      logic [Q_BITS-1:0]    stall_q, lat_q;
      logic [FL_BITS-1:0]   fresh_cnt [2];
      logic [Q_BITS-1:0]    smp_stall [2], smp_lat [2];
      logic [EP_BITS-1:0]   smp_ep [2];
      logic [LEN_BITS-1:0]  smp_len [2];
      mode_result_type      expected_modes [$];
      int                   errors;

      function new();
         cutoff = CUTOFF_RESET;
         ll_code = LL_CODE_RESET;
         ls_code = LS_CODE_RESET;
         fresh_lim = FRESH_LIM_RESET;
         cur_mode = MODE_NONE;
         decided = MODE_NONE;
         decide_sum = '0;
         measure_sum = '0;
         snap = '0;
         first_meas = 1;
         have_metrics = 0;
         stall_q = '0;
         lat_q = '0;
         for (int i = 0; i < 2; i++) begin
            fresh_cnt[i] = '0;
            smp_stall[i] = '0;
            smp_lat[i] = '0;
            smp_ep[i] = '0;
            smp_len[i] = '0;
         end
         errors = 0;
      endfunction

      function void write_reg(logic [CSR_IDX_BITS-1:0] idx, logic [31:0] val);
         case (idx)
            CSR_CUTOFF:    cutoff = val;
            CSR_LL_CODE:   ll_code = val[15:0];
            CSR_LS_CODE:   ls_code = val[15:0];
            CSR_FRESH_LIM: fresh_lim = val[7:0];
            default: ;
         endcase
      endfunction

      // floor(num * 2^F / den), saturated to the Q format
      function logic [Q_BITS-1:0] q_divide(logic [CNT_W-1:0] num, logic [CNT_W-1:0] den);
         logic [127:0] q;
         q = ({80'd0, num} << FRAC_W) / {80'd0, den};
         return (q > {80'd0, {Q_BITS{1'b1}}}) ? {Q_BITS{1'b1}} : q[Q_BITS-1:0];
      endfunction

      function logic [MODE_BITS-1:0] cost_pick(logic [31:0] len, logic is_get,
                                               logic [15:0] ep);
         logic [63:0]  pkts, alpha, f64, c;
         int           mine, other;
         bit           in_ll, fresh;
         longint       n, d;
         logic [127:0] lhs, rhs;
         logic [MODE_BITS-1:0] pick;
         pkts = ({32'd0, len} + 64'd63) >> 6;
         alpha = (pkts + 64'd1534) >> 10;
         f64 = is_get ? {32'd0, len} : 64'd5 * {32'd0, len};
         in_ll = (decided == ll_code);
         mine = in_ll ? 1 : 0;
         other = in_ll ? 0 : 1;
         fresh_cnt[mine] = fresh_lim;
         smp_stall[mine] = stall_q;
         smp_lat[mine] = lat_q;
         smp_ep[mine] = ep;
         smp_len[mine] = len;
         if (fresh_cnt[other] > 0) fresh_cnt[other]--;
         fresh = fresh_cnt[other] > 0 && smp_ep[other] == ep && smp_len[other] == len;
         if (in_ll) begin
            if (fresh) begin
               n = longint'(smp_lat[other]) - longint'(lat_q);
               d = longint'(stall_q) - longint'(smp_stall[other]);
               c = 800 * alpha;
            end else begin
               n = longint'(lat_q); d = longint'(stall_q); c = 200 * alpha;
            end
         end else begin
            if (fresh) begin
               n = longint'(lat_q) - longint'(smp_lat[other]);
               d = longint'(smp_stall[other]) - longint'(stall_q);
               c = 800 * alpha;
            end else begin
               n = longint'(lat_q); d = 3 * longint'(stall_q); c = 100 * alpha;
            end
         end
         if (d == 0) begin
            pick = ll_code;
         end else begin
            if (d < 0) begin
               d = -d;
               n = -n;
            end
            if (n < 0) begin
               pick = ls_code;
            end else begin
               lhs = {64'd0, f64} * {64'd0, 64'(d)};
               rhs = {64'd0, 64 * c} * {64'd0, 64'(n)};
               if (in_ll) pick = (lhs > rhs) ? ls_code : ll_code;
               else pick = (lhs < rhs) ? ll_code : ls_code;
            end
         end
         decided = pick;
         return pick;
      endfunction

      function void take_measurement(logic [31:0] len, logic [4:0][CNT_W-1:0] cnt);
         logic [CNT_W-1:0] req_stl, rsp_stl;
         measure_sum += {32'd0, len};
         if (measure_sum <= {32'd0, cutoff}) return;
         measure_sum = '0;
         if (cnt[3] > snap[3] && cnt[0] > snap[0] && !first_meas) begin
            req_stl = cnt[1] - snap[1];
            rsp_stl = cnt[4] - snap[4];
            lat_q = q_divide(cnt[2] - snap[2], cnt[3] - snap[3]);
            // A response stall delta above the request one counts as no stall.
            stall_q = (rsp_stl >= req_stl) ? '0 : q_divide(req_stl - rsp_stl, cnt[0] - snap[0]);
            have_metrics = 1;
         end else begin
            first_meas = 0;
         end
         snap = cnt;
      endfunction

      function void note_post(post_type p);
         logic [MODE_BITS-1:0] next;
         if (p.op == OP_SHORT) begin
            cur_mode = ll_code;
            expected_modes.push_back('{ll_code, 1'b1});
            return;
         end
         next = cur_mode;
         decide_sum += {32'd0, p.len};
         if (decide_sum <= {32'd0, cutoff}) begin
            next = ll_code;
         end else if (have_metrics) begin
            decide_sum = '0;
            next = cost_pick(p.len, p.is_get, p.ep);
         end
         expected_modes.push_back('{next, next != cur_mode});
         cur_mode = next;
         take_measurement(p.len, p.cnt);
      endfunction

      function void check_result(logic [RSP_DATA_BITS-1:0] data);
         mode_result_type want;
         if (expected_modes.size() == 0) begin
            $error("response beat with no post waiting: %h", data);
            errors++;
            return;
         end
         want = expected_modes.pop_front();
         if (data[15:0] !== want.mode) begin
            $error("routing_mode expected %h actual %h", want.mode, data[15:0]);
            errors++;
         end
         if (data[16] !== want.changed) begin
            $error("mode_changed expected %b actual %b", want.changed, data[16]);
            errors++;
         end
      endfunction
   endclass

   logic                      clock;
   logic                      reset;
   logic                      csr_valid;
   logic                      csr_ready;
   logic [CSR_IDX_BITS-1:0]   csr_index;
   logic [CSR_DATA_BITS-1:0]  csr_data;
   logic                      req_tvalid;
   logic                      req_tready;
   logic [REQ_W-1:0]          req_tdata;
   logic                      req_tuser;
   logic                      rsp_tvalid;
   logic                      rsp_tready;
   logic [RSP_DATA_BITS-1:0]  rsp_tdata;

   mode_scoreboard        sb;
   logic [4:0][CNT_W-1:0] counters;
   int                    burst_left;
   int                    idle_cycles;
   int                    stall_style;
   int                    stall_timer;

   adaptive_routing_mode_selector u_top (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial clock = 1'b0;
   always #2 clock = ~clock;

   // Receiver: the stall style changes every so often, including a stretch
   // of plain readiness.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_timer <= 0;
         stall_style <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata);
         if (stall_timer == 0) begin
            stall_style <= $urandom_range(0, 2);
            stall_timer <= $urandom_range(20, 150);
         end else begin
            stall_timer <= stall_timer - 1;
         end
         case (stall_style)
            0: rsp_tready <= 1'b1;
            1: rsp_tready <= $urandom_range(0, 1);
            default: rsp_tready <= ($urandom_range(0, 7) == 0);
         endcase
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_MAX) begin
         $display("== FAIL ==");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic write_csr(logic [CSR_IDX_BITS-1:0] idx, logic [31:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sb.write_reg(idx, val);
   endtask

   task automatic set_regs(logic [31:0] cut, logic [15:0] ll, logic [15:0] ls,
                           logic [7:0] lim);
      write_csr(CSR_CUTOFF, cut);
      write_csr(CSR_LL_CODE, {16'd0, ll});
      write_csr(CSR_LS_CODE, {16'd0, ls});
      write_csr(CSR_FRESH_LIM, {24'd0, lim});
      csr_valid <= 1'b0;
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (sb.expected_modes.size() != 0) @(posedge clock);
      repeat (DRAIN) @(posedge clock);
   endtask

   // Bursts of random length separated by random gaps; valid stays high
   // inside a burst.
   task automatic send_post(post_type p);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         if ($urandom_range(0, 3) != 0) begin
            req_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tuser <= p.op;
      req_tdata <= REQ_W'({p.cnt[4], p.cnt[3], p.cnt[2], p.cnt[1], p.cnt[0],
                           p.ep, p.is_get, p.len});
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_post(p);
   endtask

   function automatic post_type make_post(logic op, logic [31:0] len, logic is_get,
                                          logic [15:0] ep);
      post_type p;
      p.op = op;
      p.len = len;
      p.is_get = is_get;
      p.ep = ep;
      p.cnt = counters;
      return p;
   endfunction

   // Mostly well-behaved counter growth, with occasional full random values,
   // frozen counters and response stalls that outgrow request stalls.
   task automatic advance_counters();
      int kind;
      kind = $urandom_range(0, 19);
      if (kind == 0) begin
         for (int i = 0; i < 5; i++) counters[i] = {$urandom, $urandom} & {CNT_W{1'b1}};
      end else if (kind == 1) begin
         // frozen: zero deltas
      end else begin
         counters[0] += $urandom_range(1, 4000);
         counters[1] += $urandom_range(0, 3000);
         counters[2] += $urandom_range(0, 100000);
         counters[3] += $urandom_range(1, 60);
         counters[4] += (kind == 2) ? $urandom_range(3000, 9000) : $urandom_range(0, 800);
      end
   endtask

   task automatic random_post();
      logic [31:0] len;
      logic [15:0] ep;
      int          pick;
      pick = $urandom_range(0, 9);
      if (pick < 6) begin
         case ($urandom_range(0, 3))
            0: len = 64;
            1: len = 1000;
            2: len = 2048;
            default: len = 5000;
         endcase
      end else if (pick < 9) begin
         len = $urandom_range(0, 3000);
      end else begin
         len = $urandom;
      end
      case ($urandom_range(0, 3))
         0: ep = 16'd1;
         1: ep = 16'd2;
         2: ep = 16'hFFFF;
         default: ep = $urandom;
      endcase
      advance_counters();
      send_post(make_post(($urandom_range(0, 9) == 0) ? OP_SHORT : OP_BULK,
                          len, $urandom_range(0, 1), ep));
   endtask

   initial begin
      reset <= 1'b1;
      csr_valid <= 1'b0;
      csr_index <= CSR_CUTOFF;
      csr_data <= '0;
      req_tvalid <= 1'b0;
      req_tdata <= '0;
      req_tuser <= OP_BULK;
      idle_cycles <= 0;
      sb = new();
      counters = '0;
      burst_left = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: first posts before any mode exists, then a small cutoff so
      // measurements and decisions come quickly.
      send_post(make_post(OP_BULK, 32'd0, 1'b0, 16'd0));
      send_post(make_post(OP_BULK, 32'd5000, 1'b0, 16'd0));
      send_post(make_post(OP_SHORT, 32'hFFFFFFFF, 1'b1, 16'hFFFF));
      wait_drained();
      set_regs(32'd100, 16'd3, 16'd0, 8'd5);
      counters = {48'd10, 48'd10, 48'd1000, 48'd50, 48'd100};
      send_post(make_post(OP_BULK, 32'd200, 1'b0, 16'd7));
      counters = {48'd20, 48'd500, 48'd5000, 48'd900, 48'd1100};
      send_post(make_post(OP_BULK, 32'd200, 1'b0, 16'd7));
      // no stall at all: zero denominator
      counters = {48'd20, 48'd600, 48'd9000, 48'd900, 48'd2100};
      send_post(make_post(OP_BULK, 32'd200, 1'b1, 16'd7));
      send_post(make_post(OP_BULK, 32'd200, 1'b0, 16'd7));
      // response stalls outgrow request stalls
      counters = {48'd9000, 48'd700, 48'd9900, 48'd950, 48'd3100};
      send_post(make_post(OP_BULK, 32'd200, 1'b0, 16'd7));
      counters = {48'd9100, 48'd710, 48'd19900, 48'd5950, 48'd4100};
      send_post(make_post(OP_BULK, 32'd64, 1'b0, 16'd7));
      send_post(make_post(OP_BULK, 32'd64, 1'b1, 16'd7));
      // counters at the top of their range, then wrapping
      counters = {5{48'hFFFF_FFFF_FFFF}};
      send_post(make_post(OP_BULK, 32'hFFFFFFFF, 1'b0, 16'hFFFF));
      counters = {48'd5, 48'd5, 48'd5, 48'd5, 48'd5};
      send_post(make_post(OP_BULK, 32'hFFFFFFFF, 1'b1, 16'hFFFF));
      send_post(make_post(OP_SHORT, 32'd0, 1'b0, 16'd0));
      counters = {48'd50, 48'd60, 48'd70, 48'd80, 48'd90};
      send_post(make_post(OP_BULK, 32'd1000, 1'b0, 16'd3));
      send_post(make_post(OP_BULK, 32'd1000, 1'b0, 16'd3));
      wait_drained();

      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: set_regs(32'd0, 16'd3, 16'd0, 8'd1);
            1: set_regs(32'd300, 16'hFFFF, 16'd0, 8'd255);
            2: set_regs(32'd2000, 16'd7, 16'h1234, 8'd5);
            3: set_regs(32'hFFFFFFFF, 16'd0, 16'hFFFF, 8'd3);
            4: set_regs($urandom_range(0, 5000), $urandom, $urandom, $urandom_range(1, 255));
            default: set_regs(32'd50, 16'd3, 16'd3, 8'd2);
         endcase
         repeat (225) random_post();
         wait_drained();
      end

      if (sb.errors == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
